@@ rtl/mppt_po_pkg.sv @@
// Shared types, register indexes and constants for the perturb-and-observe tracker.
// Holds the width-step helper used by the decision logic. No dependencies.
package mppt_po_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LEN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DUMP_LEVEL    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_LOW      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_MAX     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_COMPARE  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_WIDTH = 3'd7;

  localparam int LEVEL_W   = 12;
  localparam int STEP_W    = 8;
  localparam int WIDTH_W   = 10;
  localparam int COMPARE_W = 11;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_TRACK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 2'd2;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET          = 10'd200;
  localparam logic [WIDTH_W-1:0] WIDTH_BEFORE_RESTART = 10'd20;

  typedef struct packed {
    logic [15:0]          window_len;
    logic [LEVEL_W-1:0]   dump_level;
    logic [LEVEL_W-1:0]   band_low;
    logic [LEVEL_W-1:0]   band_high;
    logic [STEP_W-1:0]    step_size;
    logic [WIDTH_W-1:0]   width_max;
    logic [COMPARE_W-1:0] stop_compare;
    logic [WIDTH_W-1:0]   restart_width;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [COMPARE_W-1:0] compare;
    logic [WIDTH_W-1:0]   width;
    logic                 load_dump;
    logic                 track_led;
    logic                 stop_led;
  } res_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]   width;
    logic [WIDTH_W-1:0]   prev_width;
    logic [COMPARE_W-1:0] compare;
  } track_t;

  // one perturbation step; an up step past wmax is skipped, a down step stops at zero
  function automatic track_t nudge(track_t cur, logic up, logic [STEP_W-1:0] step,
                                   logic [WIDTH_W-1:0] wmax);
    logic [WIDTH_W:0]   sum_up;
    logic [WIDTH_W:0]   lim_dn;
    logic [WIDTH_W-1:0] step_w;
    track_t             r;
    r      = cur;
    step_w = WIDTH_W'(step);
    sum_up = {1'b0, cur.width} + {1'b0, step_w};
    lim_dn = {1'b0, wmax} + {1'b0, step_w};
    if (up) begin
      if (sum_up <= {1'b0, wmax}) begin
        r.prev_width = cur.width;
        r.width      = sum_up[WIDTH_W-1:0];
        r.compare    = {1'b0, sum_up[WIDTH_W-1:0]};
      end
    end else begin
      if ({1'b0, cur.width} <= lim_dn) begin
        r.prev_width = cur.width;
        r.width      = (cur.width >= step_w) ? (cur.width - step_w) : '0;
        r.compare    = {1'b0, r.width};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/mppt_po_decide.sv @@
// Window-end decision: stop, low-voltage release or two-step perturb-and-observe.
// Holds the tracker state; updated on commit. Depends on mppt_po_pkg.
module mppt_po_decide #(
  parameter int VSUM_W = 28,
  parameter int PSUM_W = 40,
  parameter int LVL_W  = 29
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  mppt_po_pkg::cfg_t   cfg,
  input  logic                stop,
  input  logic [VSUM_W-1:0]   vsum,
  input  logic [PSUM_W-1:0]   psum,
  input  logic [LVL_W-1:0]    dump_prod,
  input  logic [LVL_W-1:0]    low_prod,
  input  logic [LVL_W-1:0]    high_prod,
  output mppt_po_pkg::res_t   res
);

  localparam int CW = (VSUM_W > LVL_W) ? VSUM_W : LVL_W;

  logic [mppt_po_pkg::WIDTH_W-1:0]   width_now_r, width_now_nxt;
  logic [mppt_po_pkg::WIDTH_W-1:0]   width_before_r, width_before_nxt;
  logic [mppt_po_pkg::COMPARE_W-1:0] compare_r, compare_nxt;
  logic                              dump_r, dump_nxt;
  logic                              track_r, track_nxt;
  logic                              stopled_r, stopled_nxt;
  logic [PSUM_W-1:0]                 prev_power_r;

  mppt_po_pkg::track_t t0, t1, t2;
  logic below_dump, at_low, at_high, rising;

  assign below_dump = CW'(vsum) <  CW'(dump_prod);
  assign at_low     = CW'(vsum) <= CW'(low_prod);
  assign at_high    = CW'(vsum) >= CW'(high_prod);
  assign rising     = psum > prev_power_r;

  always_comb begin
    t0 = '{width: width_now_r, prev_width: width_before_r, compare: compare_r};
    if (at_low) begin
      t1 = mppt_po_pkg::nudge(t0, 1'b0, cfg.step_size, cfg.width_max);
    end else if (at_high) begin
      t1 = mppt_po_pkg::nudge(t0, 1'b1, cfg.step_size, cfg.width_max);
    end else begin
      t1 = t0;
    end
    t2 = mppt_po_pkg::nudge(t1, rising == (t1.width > t1.prev_width), cfg.step_size,
                            cfg.width_max);
  end

  always_comb begin
    width_now_nxt    = width_now_r;
    width_before_nxt = width_before_r;
    compare_nxt      = compare_r;
    dump_nxt         = dump_r;
    track_nxt        = track_r;
    stopled_nxt      = stopled_r;
    res.mode         = mppt_po_pkg::MODE_TRACK;
    if (stop) begin
      res.mode    = mppt_po_pkg::MODE_STOP;
      compare_nxt = cfg.stop_compare;
      stopled_nxt = 1'b1;
      track_nxt   = 1'b0;
    end else if (below_dump) begin
      res.mode         = mppt_po_pkg::MODE_RELEASE;
      width_now_nxt    = cfg.restart_width;
      width_before_nxt = mppt_po_pkg::WIDTH_BEFORE_RESTART;
      compare_nxt      = '0;
      dump_nxt         = 1'b1;
    end else begin
      width_now_nxt    = t2.width;
      width_before_nxt = t2.prev_width;
      compare_nxt      = t2.compare;
      track_nxt        = 1'b1;
      stopled_nxt      = 1'b0;
      dump_nxt         = 1'b0;
    end
    res.compare   = compare_nxt;
    res.width     = width_now_nxt;
    res.load_dump = dump_nxt;
    res.track_led = track_nxt;
    res.stop_led  = stopled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_now_r    <= mppt_po_pkg::WIDTH_RESET;
      width_before_r <= mppt_po_pkg::WIDTH_RESET;
      compare_r      <= '0;
      dump_r         <= 1'b0;
      track_r        <= 1'b0;
      stopled_r      <= 1'b0;
      prev_power_r   <= '0;
    end else if (commit) begin
      width_now_r    <= width_now_nxt;
      width_before_r <= width_before_nxt;
      compare_r      <= compare_nxt;
      dump_r         <= dump_nxt;
      track_r        <= track_nxt;
      stopled_r      <= stopled_nxt;
      prev_power_r   <= psum;
    end
  end

endmodule

@@ rtl/mppt_perturb_observe_pwm_core.sv @@
// Top level of the perturb-and-observe tracker: stream ports, config registers,
// sample pipeline and window accumulators. Depends on mppt_po_pkg, mppt_po_decide.
//
// Usage: each request on the in_ channel is one ADC voltage/current sample plus
// the stop input. Samples are summed over window_len samples (or until the count
// field is full); the closing sample of each window yields one request on the
// out_ channel with the decision, PWM compare, pulse width, flags and the sums.
// Other samples yield nothing.
// Throughput: one sample per cycle while the out_ channel is not stalled; the rate is set
// by the accumulator adders and the one voltage-by-current multiply per sample.
// Result path: out_tvalid rises once the closing sample has passed the input
// register, product register, window register and output register.
// Reset clears the pipeline, the sums and the tracker state; the config
// registers take their default values. No clearing pass is needed.
// When out_tready is low the result waits in the output register; samples
// keep flowing until a further window end reaches the full pipeline, after
// which in_tready drops. Config writes go through cfg_wr_en/cfg_index/cfg_wdata
// and must only be made while no request is in flight.
module mppt_perturb_observe_pwm_core #(
  parameter int ADC_BITS   = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [mppt_po_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mppt_po_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // voltage_code, current_code, stop_request
  input  logic [((2*ADC_BITS+1+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // pwm_compare, pwm_width, load_dump, track_led, stop_led,
  // voltage_sum, current_sum, power_sum
  output logic [((mppt_po_pkg::COMPARE_W + mppt_po_pkg::WIDTH_W + 3
                 + 2*(ADC_BITS+COUNT_BITS) + 2*ADC_BITS+COUNT_BITS + 7)/8)*8-1:0]
                                                out_tdata,
  // mode_taken
  output logic [mppt_po_pkg::MODE_W-1:0]        out_tuser
);

  localparam int VSUM_W = ADC_BITS + COUNT_BITS;
  localparam int PROD_W = 2 * ADC_BITS;
  localparam int PSUM_W = PROD_W + COUNT_BITS;
  localparam int N_W    = COUNT_BITS + 1;
  localparam int LVL_W  = mppt_po_pkg::LEVEL_W + N_W;
  localparam int CMP_W  = (N_W > 16) ? N_W : 16;
  localparam int OUT_W  = mppt_po_pkg::COMPARE_W + mppt_po_pkg::WIDTH_W + 3
                          + 2*VSUM_W + PSUM_W;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  mppt_po_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_len    <= 16'd1000;
      cfg_r.dump_level    <= 12'd2047;
      cfg_r.band_low      <= 12'd2559;
      cfg_r.band_high     <= 12'd3839;
      cfg_r.step_size     <= 8'd10;
      cfg_r.width_max     <= 10'd650;
      cfg_r.stop_compare  <= 11'd1084;
      cfg_r.restart_width <= 10'd200;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mppt_po_pkg::CFG_WINDOW_LEN:    cfg_r.window_len    <= cfg_wdata;
        mppt_po_pkg::CFG_DUMP_LEVEL:    cfg_r.dump_level    <= cfg_wdata[11:0];
        mppt_po_pkg::CFG_BAND_LOW:      cfg_r.band_low      <= cfg_wdata[11:0];
        mppt_po_pkg::CFG_BAND_HIGH:     cfg_r.band_high     <= cfg_wdata[11:0];
        mppt_po_pkg::CFG_STEP_SIZE:     cfg_r.step_size     <= cfg_wdata[7:0];
        mppt_po_pkg::CFG_WIDTH_MAX:     cfg_r.width_max     <= cfg_wdata[9:0];
        mppt_po_pkg::CFG_STOP_COMPARE:  cfg_r.stop_compare  <= cfg_wdata[10:0];
        mppt_po_pkg::CFG_RESTART_WIDTH: cfg_r.restart_width <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic                  a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  logic [ADC_BITS-1:0]   a_v_r, a_c_r, b_v_r, b_c_r;
  logic                  a_stop_r, b_stop_r, c_stop_r;
  logic [PROD_W-1:0]     b_p_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [VSUM_W-1:0]     vacc_r, cacc_r, vacc_nxt, cacc_nxt;
  logic [PSUM_W-1:0]     pacc_r, pacc_nxt;
  logic [VSUM_W-1:0]     c_vsum_r, c_csum_r;
  logic [PSUM_W-1:0]     c_psum_r;
  logic [LVL_W-1:0]      c_dump_prod_r, c_low_prod_r, c_high_prod_r;
  logic [LVL_W-1:0]      dump_prod_nxt, low_prod_nxt, high_prod_nxt;
  logic [N_W-1:0]        n_nxt;
  logic                  b_end;
  logic                  out_free, c_ready, c_go, b_go, b_ready, a_ready;

  mppt_po_pkg::res_t     dec_res, out_res_r;
  logic [VSUM_W-1:0]     out_vsum_r, out_csum_r;
  logic [PSUM_W-1:0]     out_psum_r;

  assign out_free = !out_valid_r || out_tready;
  assign c_ready  = !c_valid_r || out_free;
  assign c_go     = c_valid_r && out_free;
  assign b_go     = b_valid_r && (!b_end || c_ready);
  assign b_ready  = !b_valid_r || b_go;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_tready = a_ready;

  assign n_nxt    = N_W'(count_r) + N_W'(1);
  assign b_end    = (CMP_W'(n_nxt) >= CMP_W'(cfg_r.window_len)) || n_nxt[COUNT_BITS];
  assign vacc_nxt = vacc_r + VSUM_W'(b_v_r);
  assign cacc_nxt = cacc_r + VSUM_W'(b_c_r);
  assign pacc_nxt = pacc_r + PSUM_W'(b_p_r);
  assign dump_prod_nxt = LVL_W'(cfg_r.dump_level) * LVL_W'(n_nxt);
  assign low_prod_nxt  = LVL_W'(cfg_r.band_low)   * LVL_W'(n_nxt);
  assign high_prod_nxt = LVL_W'(cfg_r.band_high)  * LVL_W'(n_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      vacc_r      <= '0;
      cacc_r      <= '0;
      pacc_r      <= '0;
    end else begin
      if (a_ready) a_valid_r <= in_tvalid;
      if (b_ready) b_valid_r <= a_valid_r;
      if (c_ready) c_valid_r <= b_go && b_end;
      if (out_free) out_valid_r <= c_valid_r;
      if (b_go) begin
        if (b_end) begin
          count_r <= '0;
          vacc_r  <= '0;
          cacc_r  <= '0;
          pacc_r  <= '0;
        end else begin
          count_r <= n_nxt[COUNT_BITS-1:0];
          vacc_r  <= vacc_nxt;
          cacc_r  <= cacc_nxt;
          pacc_r  <= pacc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_tvalid) begin
      a_v_r    <= in_tdata[ADC_BITS-1:0];
      a_c_r    <= in_tdata[2*ADC_BITS-1:ADC_BITS];
      a_stop_r <= in_tdata[2*ADC_BITS];
    end
    if (b_ready && a_valid_r) begin
      b_v_r    <= a_v_r;
      b_c_r    <= a_c_r;
      b_p_r    <= PROD_W'(a_v_r) * PROD_W'(a_c_r);
      b_stop_r <= a_stop_r;
    end
    if (b_go && b_end) begin
      c_vsum_r      <= vacc_nxt;
      c_csum_r      <= cacc_nxt;
      c_psum_r      <= pacc_nxt;
      c_stop_r      <= b_stop_r;
      c_dump_prod_r <= dump_prod_nxt;
      c_low_prod_r  <= low_prod_nxt;
      c_high_prod_r <= high_prod_nxt;
    end
    if (c_go) begin
      out_res_r  <= dec_res;
      out_vsum_r <= c_vsum_r;
      out_csum_r <= c_csum_r;
      out_psum_r <= c_psum_r;
    end
  end

  mppt_po_decide #(
    .VSUM_W (VSUM_W),
    .PSUM_W (PSUM_W),
    .LVL_W  (LVL_W)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (c_go),
    .cfg       (cfg_r),
    .stop      (c_stop_r),
    .vsum      (c_vsum_r),
    .psum      (c_psum_r),
    .dump_prod (c_dump_prod_r),
    .low_prod  (c_low_prod_r),
    .high_prod (c_high_prod_r),
    .res       (dec_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.mode;
  assign out_tdata  = OUT_TD_W'({out_psum_r, out_csum_r, out_vsum_r,
                                 out_res_r.stop_led, out_res_r.track_led,
                                 out_res_r.load_dump, out_res_r.width,
                                 out_res_r.compare});

  a_window_close: assert property (@(posedge clk) disable iff (!rst_n)
    (b_go && b_end) |=> (c_valid_r && count_r == '0))
    else $error("window close did not load decision stage or clear count");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    c_go |=> out_valid_r)
    else $error("committed decision missing from output register");

  a_release_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser == mppt_po_pkg::MODE_RELEASE)
      |-> (out_res_r.compare == '0 && out_res_r.load_dump))
    else $error("release result without zero compare and released load");

endmodule
